>>> rtl/ndd_pkg.sv
// Shared types and constants for the nibble dictionary decoder.
`default_nettype none

package ndd_pkg;

    // Counter width for byte positions and decoded byte counts
    localparam int CNT_W      = 24;
    localparam int DICT_SIZE  = 30;
    localparam int DICT_IDX_W = 5;
    localparam int LOAD_W     = 5;
    localparam int NIB_W      = 4;
    localparam int BYTE_W     = 8;

    // Dictionary index of the first two-nibble code, minus one (0,v reads 14+v)
    localparam logic [DICT_IDX_W-1:0] LONG_CODE_BASE = DICT_IDX_W'(14);
    localparam logic [LOAD_W-1:0]     DICT_FULL      = LOAD_W'(DICT_SIZE);

    // Result queue geometry
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = 2;
    localparam int FIFO_CNT_W = 3;

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_COMPRESSED_LENGTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_EXPECTED_LENGTH   = 2'd1;

    typedef enum logic [1:0] {
        ST_OK           = 2'd0,
        ST_LIT_IN_DICT  = 2'd1,
        ST_LEN_MISMATCH = 2'd2,
        ST_SHORT_BLOCK  = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        STG_CODE     = 2'd0,
        STG_ONE_ZERO = 2'd1,
        STG_TWO_ZERO = 2'd2,
        STG_LIT_HIGH = 2'd3
    } stage_t;

    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              is_status;
        status_t           status;
        logic              last;
    } result_t;

    // Up to two results pushed in one step; second only with first
    typedef struct packed {
        logic    v0;
        logic    v1;
        result_t r0;
        result_t r1;
    } fifo_push_t;

    function automatic result_t make_data(input logic [BYTE_W-1:0] b);
        result_t r;
        r.out_byte  = b;
        r.is_status = 1'b0;
        r.status    = ST_OK;
        r.last      = 1'b0;
        return r;
    endfunction

    function automatic result_t make_status(input status_t st);
        result_t r;
        r.out_byte  = '0;
        r.is_status = 1'b1;
        r.status    = st;
        r.last      = 1'b1;
        return r;
    endfunction

endpackage

`default_nettype wire

>>> rtl/ndd_result_fifo.sv
// Four-entry result queue: up to two words written per cycle, one word read.
`default_nettype none

module ndd_result_fifo (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire ndd_pkg::fifo_push_t push,
    output logic                   room2,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output ndd_pkg::result_t       head
);
    import ndd_pkg::*;

    result_t               mem [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] wr_ptr_reg;
    logic [FIFO_PTR_W-1:0] wr_ptr_next;
    logic [FIFO_PTR_W-1:0] rd_ptr_reg;
    logic [FIFO_PTR_W-1:0] rd_ptr_next;
    logic [FIFO_CNT_W-1:0] cnt_reg;
    logic [FIFO_CNT_W-1:0] cnt_next;
    logic [FIFO_CNT_W-1:0] n_push;
    logic                  pop;

    // Status of the queue, from registers only
    assign out_valid = (cnt_reg != '0);
    assign room2     = (cnt_reg <= FIFO_CNT_W'(FIFO_DEPTH - 2));
    assign head      = mem[rd_ptr_reg];
    assign pop       = out_valid && out_ready;

    // Advance pointers and occupancy
    always_comb
    begin
        n_push      = FIFO_CNT_W'(push.v0) + FIFO_CNT_W'(push.v1);
        wr_ptr_next = wr_ptr_reg + n_push[FIFO_PTR_W-1:0];
        rd_ptr_next = rd_ptr_reg + FIFO_PTR_W'(pop);
        cnt_next    = cnt_reg + n_push - FIFO_CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Store pushed words
    always_ff @(posedge clk)
    begin
        if (push.v0)
        begin
            mem[wr_ptr_reg] <= push.r0;
        end
        if (push.v1)
        begin
            mem[wr_ptr_reg + FIFO_PTR_W'(1)] <= push.r1;
        end
    end

    a_second_needs_first: assert property (@(posedge clk) disable iff (!rst_n)
        push.v1 |-> push.v0)
        else $error("second result pushed without first");

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push.v0 |-> room2)
        else $error("result queue push without room");

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= FIFO_CNT_W'(FIFO_DEPTH))
        else $error("result queue count out of range");

endmodule

`default_nettype wire

>>> rtl/nibble_dictionary_decoder_core.sv
// Top level of the nibble dictionary decoder: block state, nibble step and ports.
`default_nettype none

// Decodes one compressed block fed one byte per input word. The first 30
// bytes of a block fill the dictionary and are taken one per cycle while the
// result queue has room for two words; every later byte is decoded nibble by
// nibble, high nibble first, since the step reads one dictionary entry at a
// time and pushes at most two result words into a four-entry result queue.
// The queue returns one result word per cycle while out_ready is high and
// decouples the two sides, so a new byte is taken while results still wait.
// Each block ends with one status word (last = 1); the next byte starts a
// new block. The user must write compressed_length and expected_length through
// the configuration port while the decoder is idle; the core does not check it.
module nibble_dictionary_decoder_core (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [ndd_pkg::BYTE_W-1:0]    data_byte,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic [ndd_pkg::BYTE_W-1:0]         out_byte,
    output logic                               is_status,
    output logic [1:0]                         status,
    output logic                               last,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [ndd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [ndd_pkg::CNT_W-1:0]     cfg_data
);
    import ndd_pkg::*;

    // Configuration
    logic [CNT_W-1:0] comp_len_reg;
    logic [CNT_W-1:0] exp_len_reg;

    // Block state
    logic [BYTE_W-1:0] dict_reg [DICT_SIZE];
    logic [LOAD_W-1:0] load_cnt_reg;
    logic [LOAD_W-1:0] load_cnt_next;
    logic [CNT_W-1:0]  in_pos_reg;
    logic [CNT_W-1:0]  in_pos_next;
    stage_t            stage_reg;
    stage_t            stage_next;
    logic [NIB_W-1:0]  lit_reg;
    logic [NIB_W-1:0]  lit_next;
    logic [CNT_W-1:0]  out_cnt_reg;
    logic [CNT_W-1:0]  out_cnt_next;

    // Input word holding register
    logic              work_valid_reg;
    logic [BYTE_W-1:0] work_byte_reg;
    logic              phase_reg;
    logic              phase_next;

    // Step signals
    logic                  room2;
    logic                  step_fire;
    logic                  byte_done;
    logic                  clear_blk;
    logic                  dict_we;
    logic                  in_acc;
    logic [NIB_W-1:0]      nib;
    logic [CNT_W-1:0]      pos_inc;
    logic [CNT_W-1:0]      pos_cur;
    logic [DICT_IDX_W-1:0] dict_idx;
    logic [BYTE_W-1:0]     dict_rd;
    logic [BYTE_W-1:0]     lit_val;
    logic                  lit_hit;
    logic                  emit_v;
    logic [BYTE_W-1:0]     emit_b;
    logic                  fin;
    logic [CNT_W-1:0]      cnt_new;
    fifo_push_t            push;
    result_t               head;

    assign cfg_ready = 1'b1;
    assign step_fire = work_valid_reg && room2;
    assign in_ready  = !work_valid_reg || (step_fire && byte_done);
    assign in_acc    = in_valid && in_ready;

    // Nibble select and dictionary lookup
    assign nib      = phase_reg ? work_byte_reg[NIB_W-1:0] : work_byte_reg[BYTE_W-1:NIB_W];
    assign pos_inc  = in_pos_reg + CNT_W'(1);
    assign pos_cur  = phase_reg ? in_pos_reg : pos_inc;
    assign dict_idx = (stage_reg == STG_CODE) ? (DICT_IDX_W'(nib) - DICT_IDX_W'(1))
                                              : (DICT_IDX_W'(nib) + LONG_CODE_BASE);
    assign dict_rd  = dict_reg[dict_idx];
    assign lit_val  = {lit_reg, nib};

    // Compare the literal against every dictionary entry
    always_comb
    begin
        lit_hit = 1'b0;
        for (int i = 0; i < DICT_SIZE; i++)
        begin
            if (dict_reg[i] == lit_val)
            begin
                lit_hit = 1'b1;
            end
        end
    end

    // Step: one dictionary byte or one nibble of a code byte
    always_comb
    begin
        load_cnt_next = load_cnt_reg;
        in_pos_next   = in_pos_reg;
        stage_next    = stage_reg;
        lit_next      = lit_reg;
        out_cnt_next  = out_cnt_reg;
        phase_next    = phase_reg;
        byte_done     = 1'b0;
        clear_blk     = 1'b0;
        dict_we       = 1'b0;
        emit_v        = 1'b0;
        emit_b        = '0;
        fin           = 1'b0;
        cnt_new       = out_cnt_reg;
        push          = '0;

        if (load_cnt_reg != DICT_FULL)
        begin
            // Dictionary load
            byte_done = 1'b1;
            if (comp_len_reg < CNT_W'(DICT_SIZE))
            begin
                push.v0 = 1'b1;
                push.r0 = make_status(ST_SHORT_BLOCK);
                fin     = 1'b1;
            end
            else
            begin
                dict_we       = 1'b1;
                load_cnt_next = load_cnt_reg + LOAD_W'(1);
                in_pos_next   = pos_inc;
                if (pos_inc >= comp_len_reg)
                begin
                    push.v0 = 1'b1;
                    push.r0 = make_status((out_cnt_reg == exp_len_reg) ? ST_OK
                                                                       : ST_LEN_MISMATCH);
                    fin     = 1'b1;
                end
            end
        end
        else
        begin
            in_pos_next = pos_cur;
            case (stage_reg)
                STG_CODE:
                begin
                    if (nib != '0)
                    begin
                        emit_v = 1'b1;
                        emit_b = dict_rd;
                    end
                    else
                    begin
                        stage_next = STG_ONE_ZERO;
                    end
                end
                STG_ONE_ZERO:
                begin
                    if (nib != '0)
                    begin
                        emit_v     = 1'b1;
                        emit_b     = dict_rd;
                        stage_next = STG_CODE;
                    end
                    else
                    begin
                        stage_next = STG_TWO_ZERO;
                    end
                end
                STG_TWO_ZERO:
                begin
                    lit_next   = nib;
                    stage_next = STG_LIT_HIGH;
                end
                default:
                begin
                    stage_next = STG_CODE;
                    lit_next   = '0;
                    if (lit_hit)
                    begin
                        push.v0 = 1'b1;
                        push.r0 = make_status(ST_LIT_IN_DICT);
                        fin     = 1'b1;
                    end
                    else
                    begin
                        emit_v = 1'b1;
                        emit_b = lit_val;
                    end
                end
            endcase

            // Emit a data word and check for the early stop
            if (emit_v)
            begin
                push.v0 = 1'b1;
                push.r0 = make_data(emit_b);
                if (out_cnt_reg != '1)
                begin
                    cnt_new = out_cnt_reg + CNT_W'(1);
                end
                out_cnt_next = cnt_new;
                if ((({1'b0, pos_cur} + (CNT_W+1)'(1)) >= {1'b0, comp_len_reg})
                    && (cnt_new == exp_len_reg))
                begin
                    push.v1 = 1'b1;
                    push.r1 = make_status(ST_OK);
                    fin     = 1'b1;
                end
            end

            // Data end after the low nibble
            if (!fin && phase_reg && (pos_cur >= comp_len_reg))
            begin
                fin = 1'b1;
                if (emit_v)
                begin
                    push.v1 = 1'b1;
                    push.r1 = make_status((cnt_new == exp_len_reg) ? ST_OK : ST_LEN_MISMATCH);
                end
                else
                begin
                    push.v0 = 1'b1;
                    push.r0 = make_status((cnt_new == exp_len_reg) ? ST_OK : ST_LEN_MISMATCH);
                end
            end

            if (fin || phase_reg)
            begin
                byte_done = 1'b1;
            end
            else
            begin
                phase_next = 1'b1;
            end
        end

        // Drop the rest of the block state at its end
        if (fin)
        begin
            clear_blk     = 1'b1;
            load_cnt_next = '0;
            in_pos_next   = '0;
            stage_next    = STG_CODE;
            lit_next      = '0;
            out_cnt_next  = '0;
        end
        if (byte_done)
        begin
            phase_next = 1'b0;
        end

        // Hold everything when no step is taken
        if (!step_fire)
        begin
            load_cnt_next = load_cnt_reg;
            in_pos_next   = in_pos_reg;
            stage_next    = stage_reg;
            lit_next      = lit_reg;
            out_cnt_next  = out_cnt_reg;
            phase_next    = phase_reg;
            dict_we       = 1'b0;
            clear_blk     = 1'b0;
            push          = '0;
        end
    end

    // Block state and input holding register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            load_cnt_reg   <= '0;
            in_pos_reg     <= '0;
            stage_reg      <= STG_CODE;
            lit_reg        <= '0;
            out_cnt_reg    <= '0;
            phase_reg      <= 1'b0;
            work_valid_reg <= 1'b0;
        end
        else
        begin
            load_cnt_reg <= load_cnt_next;
            in_pos_reg   <= in_pos_next;
            stage_reg    <= stage_next;
            lit_reg      <= lit_next;
            out_cnt_reg  <= out_cnt_next;
            phase_reg    <= phase_next;
            if (in_acc)
            begin
                work_valid_reg <= 1'b1;
            end
            else if (step_fire && byte_done)
            begin
                work_valid_reg <= 1'b0;
            end
        end
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            comp_len_reg <= '0;
            exp_len_reg  <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_COMPRESSED_LENGTH: comp_len_reg <= cfg_data;
                CFG_EXPECTED_LENGTH:   exp_len_reg  <= cfg_data;
                default:               ;
            endcase
        end
    end

    // Payload: input byte and dictionary entries
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            work_byte_reg <= data_byte;
        end
        if (dict_we)
        begin
            dict_reg[load_cnt_reg] <= work_byte_reg;
        end
    end

    ndd_result_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .room2     (room2),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .head      (head)
    );

    assign out_byte  = head.out_byte;
    assign is_status = head.is_status;
    assign status    = head.status;
    assign last      = head.last;

    a_decode_after_load: assert property (@(posedge clk) disable iff (!rst_n)
        (stage_reg != STG_CODE) |-> (load_cnt_reg == DICT_FULL))
        else $error("code stage left idle before dictionary was full");

    a_low_nibble_pending: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg |-> (work_valid_reg && (load_cnt_reg == DICT_FULL)))
        else $error("low nibble pending without a code byte");

    a_clear_on_end: assert property (@(posedge clk) disable iff (!rst_n)
        clear_blk |=> ((load_cnt_reg == '0) && (out_cnt_reg == '0) && (in_pos_reg == '0)))
        else $error("block state not cleared after status");

    a_status_ends_step: assert property (@(posedge clk) disable iff (!rst_n)
        (push.v0 && push.r0.is_status) |-> (clear_blk && !push.v1))
        else $error("status word not the final word of a block");

endmodule

`default_nettype wire

>>> sim/tb.sv
// Self-checking testbench for the nibble dictionary decoder core.
module tb;
    import ndd_pkg::*;

    // Code lengths in nibbles, used to shape generated blocks
    localparam int CODE_SHORT = 1;
    localparam int CODE_LONG  = 2;
    localparam int CODE_LIT   = 4;
    localparam logic [CNT_W-1:0] LEN_MAX = {CNT_W{1'b1}};
    localparam int HOLD_CYCLES = 300;
    localparam int TOTAL_BYTES = 170;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 in_valid  = 1'b0;
    logic                 in_ready;
    logic [BYTE_W-1:0]    data_byte = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    logic [BYTE_W-1:0]    out_byte;
    logic                 is_status;
    logic [1:0]           status;
    logic                 last;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CNT_W-1:0]     cfg_data  = '0;

    // Shadow decoder state
    logic [BYTE_W-1:0] dict_mem [DICT_SIZE];
    int                loaded    = 0;
    logic [CNT_W-1:0]  byte_pos  = '0;
    logic [CNT_W-1:0]  emitted   = '0;
    logic [CNT_W-1:0]  comp_len  = '0;
    logic [CNT_W-1:0]  exp_len   = '0;
    stage_t            stage     = STG_CODE;
    logic [NIB_W-1:0]  lit_high  = '0;

    result_t           want_q [$];
    logic [BYTE_W-1:0] pending [$];
    int                code_shape [$];

    int err_cnt     = 0;
    int queued      = 0;
    int bytes_taken = 0;
    int words_seen  = 0;
    int status_seen [4] = '{0, 0, 0, 0};

    // Sender burst control, receiver stall control
    int          burst_left = 0;
    int          gap_left   = 0;
    int          hold_req   = 0;
    int          hold_ack   = 0;
    int          hold_left  = 0;
    logic [7:0]  cyc        = '0;

    nibble_dictionary_decoder_core uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .data_byte (data_byte),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_byte  (out_byte),
        .is_status (is_status),
        .status    (status),
        .last      (last),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    initial
    begin
        #4000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    task automatic log_mismatch(input string msg);
        err_cnt++;
        if (err_cnt <= 40)
            $display("[%0t] MISMATCH %s", $time, msg);
    endtask

    function automatic bit holds(input logic [BYTE_W-1:0] tbl [DICT_SIZE],
                                 input logic [BYTE_W-1:0] v);
        for (int i = 0; i < DICT_SIZE; i++)
            if (tbl[i] == v)
                return 1'b1;
        return 1'b0;
    endfunction

    // Queue a status word and clear the per-block state
    function automatic void emit_status(input status_t st);
        result_t r;
        r.out_byte  = '0;
        r.is_status = 1'b1;
        r.status    = st;
        r.last      = 1'b1;
        want_q = {want_q, r};
        loaded   = 0;
        byte_pos = '0;
        stage    = STG_CODE;
        lit_high = '0;
        emitted  = '0;
    endfunction

    function automatic status_t length_status();
        return (emitted == exp_len) ? ST_OK : ST_LEN_MISMATCH;
    endfunction

    // Advance the shadow decoder by one compressed byte
    function automatic void decode_byte(input logic [BYTE_W-1:0] b);
        logic [NIB_W-1:0]  nib;
        logic [BYTE_W-1:0] word;
        logic              hit;
        result_t           r;
        if (loaded < DICT_SIZE)
        begin
            if (comp_len < DICT_SIZE)
            begin
                emit_status(ST_SHORT_BLOCK);
                return;
            end
            dict_mem[loaded] = b;
            loaded++;
            byte_pos = byte_pos + 1'b1;
            if (byte_pos >= comp_len)
                emit_status(length_status());
            return;
        end
        byte_pos = byte_pos + 1'b1;
        for (int h = 0; h < 2; h++)
        begin
            nib  = (h == 0) ? b[7:4] : b[3:0];
            hit  = 1'b0;
            word = '0;
            case (stage)
                STG_CODE:
                    if (nib != 0)
                    begin
                        word = dict_mem[nib - 1];
                        hit  = 1'b1;
                    end
                    else
                        stage = STG_ONE_ZERO;
                STG_ONE_ZERO:
                    if (nib != 0)
                    begin
                        word  = dict_mem[14 + nib];
                        hit   = 1'b1;
                        stage = STG_CODE;
                    end
                    else
                        stage = STG_TWO_ZERO;
                STG_TWO_ZERO:
                begin
                    lit_high = nib;
                    stage    = STG_LIT_HIGH;
                end
                default:
                begin
                    word     = {lit_high, nib};
                    stage    = STG_CODE;
                    lit_high = '0;
                    if (holds(dict_mem, word))
                    begin
                        emit_status(ST_LIT_IN_DICT);
                        return;
                    end
                    hit = 1'b1;
                end
            endcase
            if (hit)
            begin
                r.out_byte  = word;
                r.is_status = 1'b0;
                r.status    = ST_OK;
                r.last      = 1'b0;
                want_q = {want_q, r};
                if (emitted != LEN_MAX)
                    emitted = emitted + 1'b1;
                // Stop early once the count is met near the end of the data
                if (byte_pos + 1 >= comp_len && emitted == exp_len)
                begin
                    emit_status(ST_OK);
                    return;
                end
            end
        end
        if (byte_pos >= comp_len)
            emit_status(length_status());
    endfunction

    // Driver: bursts of words with random gaps, valid held until taken
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid   <= 1'b0;
            data_byte  <= '0;
            burst_left <= 0;
            gap_left   <= 0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                decode_byte(data_byte);
                bytes_taken++;
            end
            if (!in_valid || in_ready)
            begin
                if (gap_left > 0)
                begin
                    gap_left <= gap_left - 1;
                    in_valid <= 1'b0;
                end
                else if (pending.size() != 0)
                begin
                    in_valid  <= 1'b1;
                    data_byte <= pending.pop_front();
                    if (burst_left <= 1)
                    begin
                        burst_left <= $urandom_range(16, 1);
                        gap_left   <= ($urandom_range(2) == 0) ? 0 : $urandom_range(5, 1);
                    end
                    else
                        burst_left <= burst_left - 1;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Receiver: stall pattern picked from the top bits of a free-running counter, plus long hold-offs
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            hold_ack  <= 0;
            hold_left <= 0;
            cyc       <= '0;
        end
        else
        begin
            cyc <= cyc + 1'b1;
            if (hold_req != hold_ack)
            begin
                hold_ack  <= hold_req;
                hold_left <= HOLD_CYCLES;
                out_ready <= 1'b0;
            end
            else if (hold_left != 0)
            begin
                hold_left <= hold_left - 1;
                out_ready <= 1'b0;
            end
            else
            begin
                case (cyc[7:6])
                    2'd0: out_ready <= 1'b1;
                    2'd1: out_ready <= 1'($urandom_range(1));
                    2'd2: out_ready <= (cyc[1:0] == 2'd0);
                    default: out_ready <= ($urandom_range(3) != 0);
                endcase
            end
        end
    end

    // Monitor: compare each result word with the oldest prediction
    always @(posedge clk)
    begin : monitor
        result_t w;
        if (rst_n && out_valid && out_ready)
        begin
            words_seen++;
            if (want_q.size() == 0)
                log_mismatch($sformatf("unexpected word byte=%02h is_status=%0b status=%0d",
                                       out_byte, is_status, status));
            else
            begin
                w = want_q.pop_front();
                if (out_byte !== w.out_byte)
                    log_mismatch($sformatf("out_byte got %02h want %02h", out_byte, w.out_byte));
                if (is_status !== w.is_status)
                    log_mismatch($sformatf("is_status got %0b want %0b", is_status, w.is_status));
                if (status !== w.status)
                    log_mismatch($sformatf("status got %0d want %0d", status, w.status));
                if (last !== w.last)
                    log_mismatch($sformatf("last got %0b want %0b", last, w.last));
                if (w.is_status)
                    status_seen[w.status]++;
            end
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CNT_W-1:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == CFG_COMPRESSED_LENGTH)
            comp_len = val;
        else if (idx == CFG_EXPECTED_LENGTH)
            exp_len = val;
        @(negedge clk);
    endtask

    task automatic set_lengths(input logic [CNT_W-1:0] c, input logic [CNT_W-1:0] e);
        write_reg(CFG_COMPRESSED_LENGTH, c);
        write_reg(CFG_EXPECTED_LENGTH, e);
    endtask

    task automatic wait_input();
        while (pending.size() != 0 || in_valid)
            @(negedge clk);
    endtask

    // Hold the sender until every predicted word has come out
    task automatic wait_drain();
        wait_input();
        while (want_q.size() != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    function automatic void add_byte(input logic [BYTE_W-1:0] b);
        pending = {pending, b};
        queued++;
    endfunction

    // Feed bytes that force the open block to end, mostly through a literal hit
    task automatic close_block();
        logic [BYTE_W-1:0] b;
        wait_input();
        while (loaded != 0)
        begin
            if (loaded < DICT_SIZE)
                b = 8'($urandom);
            else
                case (stage)
                    STG_CODE:     b = 8'h00;
                    STG_ONE_ZERO: b = {4'h0, dict_mem[0][7:4]};
                    STG_TWO_ZERO: b = dict_mem[0];
                    default:      b = {dict_mem[0][3:0], 4'h0};
                endcase
            add_byte(b);
            wait_input();
        end
    endtask

    // Pick a sequence of code lengths that fills n_data bytes, leaving at most
    // three nibbles for a cut-off code
    function automatic void build_shape(input int n_data);
        int rem;
        int len;
        code_shape.delete();
        rem = 2 * n_data;
        while (rem > 0)
        begin
            if (rem <= 3 && $urandom_range(1) == 1)
                break;
            case ($urandom_range(2))
                0: len = CODE_SHORT;
                1: len = CODE_LONG;
                default: len = CODE_LIT;
            endcase
            if (len <= rem)
            begin
                code_shape = {code_shape, len};
                rem -= len;
            end
        end
    endfunction

    // Queue one block: random dictionary, then codes following code_shape
    function automatic void push_block(input int n_data, input bit bad_lit);
        logic [BYTE_W-1:0] dict [DICT_SIZE];
        logic [NIB_W-1:0]  nibs [$];
        logic [BYTE_W-1:0] lit;
        int                n_lit;
        int                bad_at;
        int                lit_no;
        n_lit  = 0;
        lit_no = 0;
        for (int i = 0; i < DICT_SIZE; i++)
        begin
            dict[i] = 8'($urandom);
            add_byte(dict[i]);
        end
        foreach (code_shape[i])
            if (code_shape[i] == CODE_LIT)
                n_lit++;
        bad_at = (bad_lit && n_lit > 0) ? $urandom_range(n_lit - 1) : -1;
        foreach (code_shape[i])
        begin
            case (code_shape[i])
                CODE_SHORT: nibs = {nibs, 4'($urandom_range(15, 1))};
                CODE_LONG:
                begin
                    nibs = {nibs, 4'h0};
                    nibs = {nibs, 4'($urandom_range(15, 1))};
                end
                default:
                begin
                    if (lit_no == bad_at)
                        lit = dict[$urandom_range(DICT_SIZE - 1)];
                    else
                        do
                            lit = 8'($urandom);
                        while (holds(dict, lit));
                    lit_no++;
                    nibs = {nibs, 4'h0};
                    nibs = {nibs, 4'h0};
                    nibs = {nibs, lit[7:4]};
                    nibs = {nibs, lit[3:0]};
                end
            endcase
        end
        // Zero nibbles open a code that never completes
        while (nibs.size() < 2 * n_data)
            nibs = {nibs, 4'h0};
        for (int i = 0; i < nibs.size(); i += 2)
            add_byte({nibs[i], nibs[i + 1]});
    endfunction

    function automatic void push_ramp_dict();
        for (int i = 0; i < DICT_SIZE; i++)
            add_byte(i == 0 ? 8'h00 : (i == DICT_SIZE - 1 ? 8'hFF : 8'(i * 8)));
    endfunction

    initial
    begin : stimulus
        int  n_data;
        int  n_codes;
        int  e_len;
        int  p;
        bit  held;
        held = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Zero length: every byte ends a block as too short for a dictionary
        set_lengths('0, '0);
        add_byte(8'h00);
        add_byte(8'hFF);
        add_byte(8'h5A);
        wait_drain();

        // Hand-built block: short codes 1 and 15, long codes 1 and 15,
        // a literal and short codes 2 and 3, then a second block whose literal hits the dictionary
        set_lengths(24'd36, 24'd7);
        push_ramp_dict();
        add_byte(8'h1F);
        add_byte(8'h01);
        add_byte(8'h0F);
        add_byte(8'h00);
        add_byte(8'hAB);
        add_byte(8'h23);
        push_ramp_dict();
        add_byte(8'h00);
        add_byte(8'h10);
        close_block();
        wait_drain();

        // Both lengths at their maximum: only a literal hit can end the block
        set_lengths(LEN_MAX, LEN_MAX);
        build_shape(4);
        push_block(4, 1'b1);
        close_block();
        wait_drain();

        // Random phases, each with its own lengths
        p = 0;
        while (queued < TOTAL_BYTES)
        begin
            if (p % 5 == 1)
            begin
                // Dictionary-only blocks
                set_lengths(CNT_W'(DICT_SIZE),
                            ($urandom_range(1) == 0) ? '0 : CNT_W'($urandom_range(3, 1)));
                build_shape(0);
                repeat ($urandom_range(2, 1)) push_block(0, 1'b0);
            end
            else if (p % 5 == 3)
            begin
                // Lengths below the dictionary size
                set_lengths(CNT_W'($urandom_range(DICT_SIZE - 1, 1)),
                            CNT_W'($urandom_range(7)));
                repeat ($urandom_range(3, 1)) add_byte(8'($urandom));
            end
            else
            begin
                n_data = ($urandom_range(7) == 0) ? $urandom_range(12, 8) : $urandom_range(6, 1);
                if (!held)
                    n_data = 10;
                build_shape(n_data);
                n_codes = code_shape.size();
                case ($urandom_range(9))
                    0: e_len = n_codes + 1;
                    1: e_len = (n_codes > 0) ? n_codes - 1 : 0;
                    default: e_len = n_codes;
                endcase
                set_lengths(CNT_W'(DICT_SIZE + n_data), CNT_W'(e_len));
                // Stop the receiver for a long stretch while bytes keep coming
                if (!held)
                begin
                    hold_req <= hold_req + 1;
                    held = 1'b1;
                end
                repeat ($urandom_range(3, 1)) push_block(n_data, $urandom_range(5) == 0);
            end
            close_block();
            wait_drain();
            p++;
        end

        wait_drain();
        repeat (20) @(negedge clk);
        $display("Covered %0d bytes in %0d phases, %0d result words checked", bytes_taken,
                 p + 3, words_seen);
        $display("Block ends: ok %0d, literal hit %0d, length mismatch %0d, short %0d",
                 status_seen[ST_OK], status_seen[ST_LIT_IN_DICT],
                 status_seen[ST_LEN_MISMATCH], status_seen[ST_SHORT_BLOCK]);
        if (err_cnt == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
